>>> rtl/oale_pkg.sv
// Shared types and codes for the ordered array list engine.
// Holds command and status codes, field widths and the control/status structs.
// No dependencies.
package oale_pkg;

   // Field widths of the stream payloads
   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 7;
   localparam int LEN_W    = 8;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // What a freshly accepted command needs next
   localparam logic [1:0] PLAN_DONE = 2'd0;
   localparam logic [1:0] PLAN_WALK = 2'd1;
   localparam logic [1:0] PLAN_PUT  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture a transfer and set up the walk
      logic walk;   // issue one memory read and advance the address
      logic put;    // write the insert value at its position
      logic done;   // load the result register
   } oale_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] plan;       // next step for the command now on the input
      logic       walk_last;  // the read issued this cycle is the last one
      logic       is_insert;  // the command in flight is an insert
   } oale_sts_type;

endpackage

>>> rtl/ordered_array_list_engine.sv
// Ordered array list engine. Clear, unused codes and rejected commands go straight to the
// result; read, search, delete and insert first walk the entry RAM with one RAM read per
// walk step, and an insert then writes its value (an append skips the walk). The next
// transfer is taken in the cycle after the result is loaded. Reset (synchronous, active high)
// empties the list, not the entries.
// Depends on oale_pkg, oale_ctrl, oale_dp and oale_ram.
module ordered_array_list_engine
   import oale_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [39:0]             req_tdata,   // [7:0] position, [39:8] data_in
   input  logic [CMD_W-1:0]        req_tuser,   // [2:0] cmd
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,   // [31:0] data_out, [38:32] found_index,
                                                // [46:39] length_out, [47] zero
   output logic [STATUS_W-1:0]     rsp_tuser    // [2:0] status
);

   // Command and status between the sequencer and the datapath
   oale_cmd_type cmd;
   oale_sts_type sts;

   // Sequencer: accept a transfer, walk the entry RAM one address a cycle,
   // write the inserted value, then hold the result until the output is free.
   oale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Datapath: length register, bounds checks, shift/search/read over the RAM
   // and the result register that drives the output channel.
   oale_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> rtl/oale_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module oale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/oale_dp.sv
// Datapath of the ordered array list engine: length, walk address, entry RAM,
// per-command data handling and the result register.
// Depends on oale_pkg and oale_ram.
module oale_dp
   import oale_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [POS_W+DATA_W-1:0]  req_tdata,
   input  logic [CMD_W-1:0]         req_tuser,
   output logic [47:0]              rsp_tdata,
   output logic [STATUS_W-1:0]      rsp_tuser,
   input  oale_cmd_type             cmd,
   output oale_sts_type             sts
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   logic [CMD_W-1:0]  req_cmd;
   logic [POS_W-1:0]  req_pos;
   logic [DATA_W-1:0] req_val;

   assign req_cmd = req_tuser;
   assign req_pos = req_tdata[POS_W-1:0];
   assign req_val = req_tdata[POS_W+DATA_W-1:POS_W];

   logic [LW-1:0]       len_ff, len_in;
   logic [CMD_W-1:0]    op_ff, op_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       end_ff, end_in;
   logic                down_ff, down_in;
   logic                rdv_ff, rdv_in;
   logic [AW-1:0]       rda_ff, rda_in;
   logic                head_ff, head_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   dout_ff, dout_in;
   logic [AW-1:0]       fidx_ff, fidx_in;

   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [FIDX_W-1:0]   rsp_fidx_ff, rsp_fidx_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   // setup decode for the command on the input
   logic [1:0]          ld_plan;
   logic [STATUS_W-1:0] ld_status;
   logic [LW-1:0]       ld_len;
   logic [AW-1:0]       ld_addr;
   logic [AW-1:0]       ld_end;
   logic                ld_down;
   logic [CW-1:0]       pos_w;
   logic [CW-1:0]       len_w;
   logic                list_full;
   logic                list_empty;

   logic [DATA_W-1:0]   rd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [DATA_W-1:0]   wr_data;

   assign pos_w      = CW'(req_pos);
   assign len_w      = CW'(len_ff);
   assign list_full  = (len_ff == LW'(CAPACITY));
   assign list_empty = (len_ff == '0);

   always_comb begin
      ld_plan   = PLAN_DONE;
      ld_status = ST_OK;
      ld_len    = len_ff;
      ld_addr   = '0;
      ld_end    = AW'(req_pos);
      ld_down   = 1'b0;
      unique case (req_cmd)
         CMD_CLEAR: begin
            ld_len = '0;
         end
         CMD_INSERT: begin
            if (list_full) begin
               ld_status = ST_OVERFLOW;
            end else if (pos_w > len_w) begin
               ld_status = ST_BADPOS;
            end else begin
               ld_len = len_ff + 1'b1;
               if (pos_w == len_w) begin
                  ld_plan = PLAN_PUT;
               end else begin
                  // shift from the top entry down to the insert point
                  ld_plan = PLAN_WALK;
                  ld_addr = AW'(len_ff - 1'b1);
                  ld_down = 1'b1;
               end
            end
         end
         CMD_DELETE: begin
            if (list_empty) begin
               ld_status = ST_EMPTY;
            end else if (pos_w >= len_w) begin
               ld_status = ST_BADPOS;
            end else begin
               ld_len  = len_ff - 1'b1;
               ld_plan = PLAN_WALK;
               ld_addr = AW'(req_pos);
               ld_end  = AW'(len_ff - 1'b1);
            end
         end
         CMD_SEARCH: begin
            if (list_empty) begin
               ld_status = ST_EMPTY;
            end else begin
               ld_status = ST_NOTFOUND;
               ld_plan   = PLAN_WALK;
               ld_end    = AW'(len_ff - 1'b1);
            end
         end
         CMD_READ: begin
            if (list_empty) begin
               ld_status = ST_EMPTY;
            end else if (pos_w >= len_w) begin
               ld_status = ST_BADPOS;
            end else begin
               ld_plan = PLAN_WALK;
               ld_addr = AW'(req_pos);
            end
         end
         default: begin
            ld_plan = PLAN_DONE;
         end
      endcase
   end

   // insert write, and returned read data: shift, capture or compare by command
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = rda_ff;
      wr_data   = rd_data;
      dout_in   = dout_ff;
      found_in  = found_ff;
      fidx_in   = fidx_ff;
      status_in = status_ff;
      head_in   = head_ff;
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = end_ff;
         wr_data = val_ff;
      end else if (rdv_ff) begin
         head_in = 1'b0;
         case (op_ff)
            CMD_INSERT: begin
               wr_en   = 1'b1;
               wr_addr = rda_ff + 1'b1;
            end
            CMD_DELETE: begin
               if (head_ff) begin
                  dout_in = rd_data;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = rda_ff - 1'b1;
               end
            end
            CMD_SEARCH: begin
               if (!found_ff && (rd_data == val_ff)) begin
                  found_in  = 1'b1;
                  fidx_in   = rda_ff;
                  status_in = ST_OK;
               end
            end
            CMD_READ: begin
               dout_in = rd_data;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      if (cmd.load) begin
         dout_in   = '0;
         found_in  = 1'b0;
         fidx_in   = '0;
         status_in = ld_status;
         head_in   = 1'b1;
      end
   end

   always_comb begin
      len_in  = len_ff;
      op_in   = op_ff;
      val_in  = val_ff;
      addr_in = addr_ff;
      end_in  = end_ff;
      down_in = down_ff;
      rdv_in  = cmd.walk;
      rda_in  = addr_ff;
      if (cmd.load) begin
         len_in  = ld_len;
         op_in   = req_cmd;
         val_in  = req_val;
         addr_in = ld_addr;
         end_in  = ld_end;
         down_in = ld_down;
      end else if (cmd.walk) begin
         addr_in = down_ff ? addr_ff - 1'b1 : addr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_len_in    = rsp_len_ff;
      if (cmd.done) begin
         rsp_status_in = status_ff;
         rsp_data_in   = dout_ff;
         rsp_fidx_in   = FIDX_W'(fidx_ff);
         rsp_len_in    = LEN_W'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         rdv_ff <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      addr_ff       <= addr_in;
      end_ff        <= end_in;
      down_ff       <= down_in;
      rda_ff        <= rda_in;
      head_ff       <= head_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      dout_ff       <= dout_in;
      fidx_ff       <= fidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_len_ff    <= rsp_len_in;
   end

   oale_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.walk),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign sts.plan      = ld_plan;
   assign sts.walk_last = (addr_ff == end_ff);
   assign sts.is_insert = (op_ff == CMD_INSERT);

   assign rsp_tdata = {1'b0, rsp_len_ff, rsp_fidx_ff, rsp_data_ff};
   assign rsp_tuser = rsp_status_ff;

`ifndef SYNTHESIS
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAPACITY))
      else $error("list length beyond capacity");

   a_put_no_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !rdv_ff)
      else $error("insert write collides with a shift write");

   a_found_in_list: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (LW'(fidx_ff) < len_ff))
      else $error("search hit outside the list");
`endif

endmodule

>>> rtl/oale_ctrl.sv
// Controller of the ordered array list engine: sequences accept, walk,
// insert write and result hand-off; owns the result valid flag.
// Depends on oale_pkg.
module oale_ctrl
   import oale_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output oale_cmd_type cmd,
   input  oale_sts_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_TAIL = 3'd2;
   localparam logic [2:0] S_PUT  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (sts.plan)
                  PLAN_WALK: state_in = S_WALK;
                  PLAN_PUT:  state_in = S_PUT;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = sts.is_insert ? S_PUT : S_DONE;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the hand-off state");

   a_tail_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL) |-> ($past(state_ff) == S_WALK))
      else $error("tail state entered without a walk");

   a_put_from_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL && !sts.is_insert) |=> (state_ff == S_DONE))
      else $error("non-insert command reached the insert write");
`endif

endmodule
